[hw/rtl/jesc_pkg.sv]
// shared constants, register indexes and types of the julia escape-time pixel unit
`default_nettype none

package jesc_pkg;

   // field and datapath widths
   localparam int COORD_BITS     = 10;
   localparam int FRAC_BITS      = 28;
   localparam int ITER_BITS      = 10;
   localparam int INT_PART_BITS  = 12;
   localparam int Z_BITS         = FRAC_BITS + INT_PART_BITS;
   localparam int HALF_BITS      = Z_BITS / 2;
   localparam int PROD_BITS      = Z_BITS + HALF_BITS;
   localparam int SQ_BITS        = 2 * Z_BITS;
   localparam int GRAY_BITS      = 8;
   localparam int DIVIDEND_BITS  = ITER_BITS + GRAY_BITS;
   localparam int DIV_STEP_BITS  = $clog2(DIVIDEND_BITS);
   localparam int COEF_BITS      = 32;
   localparam int PITCH_BITS     = 31;
   localparam int ESC_BITS       = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_C_REAL          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_C_IMAG          = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_ORIGIN        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_ORIGIN        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_PITCH     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITERATION_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ESCAPE_SQ       = 3'd6;

   // register reset values: c = -0.4 + 0.6i, origins -1.5, pitch 3/500
   localparam logic signed [COEF_BITS-1:0] C_REAL_RESET   = -32'sd107374182;
   localparam logic signed [COEF_BITS-1:0] C_IMAG_RESET   = 32'sd161061274;
   localparam logic signed [COEF_BITS-1:0] X_ORIGIN_RESET = -32'sd402653184;
   localparam logic signed [COEF_BITS-1:0] Y_ORIGIN_RESET = -32'sd402653184;
   localparam logic [PITCH_BITS-1:0]       PITCH_RESET    = 31'd1610613;
   localparam logic [ITER_BITS-1:0]        LIMIT_RESET    = 10'd256;
   localparam logic [ESC_BITS-1:0]         ESCAPE_RESET   = 8'd100;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] c_real;
      logic signed [COEF_BITS-1:0] c_imag;
      logic signed [COEF_BITS-1:0] x_origin;
      logic signed [COEF_BITS-1:0] y_origin;
      logic [PITCH_BITS-1:0]       pixel_pitch;
      logic [ITER_BITS-1:0]        iteration_limit;
      logic [ESC_BITS-1:0]         escape_sq;
   } jesc_cfg_type;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [ITER_BITS-1:0]     divisor;
   } jesc_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [GRAY_BITS-1:0] quotient;
   } jesc_div_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/jesc_intf.sv]
// request, response and register-write channel interfaces
`default_nettype none

interface jesc_req_intf
   import jesc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] col;
   logic [COORD_BITS-1:0] row;

   modport source (output valid, output col, output row, input ready);
   modport sink   (input valid, input col, input row, output ready);
endinterface

interface jesc_rsp_intf
   import jesc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ITER_BITS-1:0] iter_count;
   logic [GRAY_BITS-1:0] gray;

   modport source (output valid, output iter_count, output gray, input ready);
   modport sink   (input valid, input iter_count, input gray, output ready);
endinterface

interface jesc_csr_intf
   import jesc_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/jesc_csr.sv]
// configuration register file written through the register-write channel
`default_nettype none

module jesc_csr
   import jesc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   jesc_csr_intf.sink  csr_bus,
   output jesc_cfg_type cfg
);

   jesc_cfg_type cfg_ff;
   jesc_cfg_type cfg_in;

   // writes are always taken
   assign csr_bus.ready = 1'b1;

   // decode one write word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_C_REAL:          cfg_in.c_real          = csr_bus.data[COEF_BITS-1:0];
            CSR_C_IMAG:          cfg_in.c_imag          = csr_bus.data[COEF_BITS-1:0];
            CSR_X_ORIGIN:        cfg_in.x_origin        = csr_bus.data[COEF_BITS-1:0];
            CSR_Y_ORIGIN:        cfg_in.y_origin        = csr_bus.data[COEF_BITS-1:0];
            CSR_PIXEL_PITCH:     cfg_in.pixel_pitch     = csr_bus.data[PITCH_BITS-1:0];
            CSR_ITERATION_LIMIT: cfg_in.iteration_limit = csr_bus.data[ITER_BITS-1:0];
            CSR_ESCAPE_SQ:       cfg_in.escape_sq       = csr_bus.data[ESC_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real          <= C_REAL_RESET;
         cfg_ff.c_imag          <= C_IMAG_RESET;
         cfg_ff.x_origin        <= X_ORIGIN_RESET;
         cfg_ff.y_origin        <= Y_ORIGIN_RESET;
         cfg_ff.pixel_pitch     <= PITCH_RESET;
         cfg_ff.iteration_limit <= LIMIT_RESET;
         cfg_ff.escape_sq       <= ESCAPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/jesc_gray_div.sv]
// restoring divider, one quotient bit per cycle, for the gray level
`default_nettype none

module jesc_gray_div
   import jesc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire jesc_div_req_type div_req,
   output jesc_div_rsp_type      div_rsp
);

   localparam logic [DIV_STEP_BITS-1:0] LAST_STEP = DIV_STEP_BITS'(DIVIDEND_BITS - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [ITER_BITS-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [ITER_BITS-1:0]     divisor_ff, divisor_in;
   logic [ITER_BITS:0]       trial;
   logic [ITER_BITS:0]       diff;
   logic                     fits;

   // trial subtract of the next dividend bit
   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[ITER_BITS-1:0] : trial[ITER_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[GRAY_BITS-1:0];

endmodule

`default_nettype wire

[hw/rtl/julia_escape_time_pixel_unit.sv]
// julia-set escape-time pixel unit: sequencer around one shared 40x20 multiplier
// Usage:
//   req_bus carries one request word per pixel (col, row). It is taken only
//   while the unit is idle; the unit works on one pixel at a time.
//   rsp_bus returns one response word per pixel: iter_count and gray.
//   csr_bus writes the seven configuration registers; it is always ready and
//   is meant to be written only while no pixel is in flight.
// Sequence:
//   setup states START_X, START_Y and LOAD_Y form the start point, then each
//   iteration takes three 40x40 products, each two passes through the shared
//   40x20 multiplier, plus magnitude and update steps; then the gray-level divider
//   runs (one quotient bit per cycle over 18 bits) and the output register is loaded
//   once it is free. An escaping pixel stops in its last iteration at the escape
//   test, once both squares are formed, before the cross product is accumulated.
//   A new pixel is taken only when the sequencer is back in idle.
// Reset: registers return to c = -0.4 + 0.6i, origins -1.5, pitch 3/500,
//   limit 256, escape bound 100; the sequencer is idle, no response pending.
// Stall: the finished response sits in an output register, so the next
//   request is taken while it waits; a further result then waits in the
//   sequencer until the output register frees.
`default_nettype none

module julia_escape_time_pixel_unit
   import jesc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   jesc_req_intf.sink   req_bus,
   jesc_rsp_intf.source rsp_bus,
   jesc_csr_intf.sink   csr_bus
);

   localparam int WIDE_BITS  = 56;
   localparam int START_BITS = PITCH_BITS + COORD_BITS;
   localparam int XX_BITS    = SQ_BITS - FRAC_BITS;
   localparam int XY_SH_BITS = SQ_BITS - FRAC_BITS + 2;

   localparam logic signed [Z_BITS-1:0] Z_MAX = {1'b0, {(Z_BITS-1){1'b1}}};
   localparam logic signed [Z_BITS-1:0] Z_MIN = {1'b1, {(Z_BITS-1){1'b0}}};

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_START_X  = 4'd1;
   localparam logic [3:0] ST_START_Y  = 4'd2;
   localparam logic [3:0] ST_LOAD_Y   = 4'd3;
   localparam logic [3:0] ST_MAG      = 4'd4;
   localparam logic [3:0] ST_SQX_LO   = 4'd5;
   localparam logic [3:0] ST_SQX_HI   = 4'd6;
   localparam logic [3:0] ST_SQY_LO   = 4'd7;
   localparam logic [3:0] ST_SQY_HI   = 4'd8;
   localparam logic [3:0] ST_XY_LO    = 4'd9;
   localparam logic [3:0] ST_XY_HI    = 4'd10;
   localparam logic [3:0] ST_XY_ACC   = 4'd11;
   localparam logic [3:0] ST_UPDATE   = 4'd12;
   localparam logic [3:0] ST_DIV_GO   = 4'd13;
   localparam logic [3:0] ST_DIV_WAIT = 4'd14;
   localparam logic [3:0] ST_FINISH   = 4'd15;

   // clamp a wide signed value to the z range
   function automatic logic signed [Z_BITS-1:0] sat_z(input logic signed [WIDE_BITS-1:0] v);
      logic [WIDE_BITS-Z_BITS:0] upper;
      upper = v[WIDE_BITS-1:Z_BITS-1];
      if ((upper == '0) || (upper == '1)) begin
         sat_z = v[Z_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         sat_z = Z_MIN;
      end else begin
         sat_z = Z_MAX;
      end
   endfunction

   // magnitude of a z value, fits unsigned in z width
   function automatic logic [Z_BITS-1:0] mag_z(input logic signed [Z_BITS-1:0] v);
      mag_z = v[Z_BITS-1] ? Z_BITS'(-v) : Z_BITS'(v);
   endfunction

   jesc_cfg_type     cfg;
   jesc_div_req_type div_req;
   jesc_div_rsp_type div_rsp;

   logic [3:0]               state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ITER_BITS-1:0]     out_count_ff, out_count_in;
   logic [GRAY_BITS-1:0]     out_gray_ff, out_gray_in;
   logic [COORD_BITS-1:0]    col_ff, col_in;
   logic [COORD_BITS-1:0]    row_ff, row_in;
   logic signed [Z_BITS-1:0] x_ff, x_in;
   logic signed [Z_BITS-1:0] y_ff, y_in;
   logic [Z_BITS-1:0]        mx_ff, mx_in;
   logic [Z_BITS-1:0]        my_ff, my_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [SQ_BITS-1:0]       sqx_ff, sqx_in;
   logic [SQ_BITS-1:0]       sqy_ff, sqy_in;
   logic [SQ_BITS:0]         xy_ff, xy_in;
   logic [ITER_BITS-1:0]     count_ff, count_in;
   logic [GRAY_BITS-1:0]     gray_ff, gray_in;

   logic [Z_BITS-1:0]           mult_a;
   logic [HALF_BITS-1:0]        mult_b;
   logic signed [WIDE_BITS-1:0] x_start_sum;
   logic signed [WIDE_BITS-1:0] y_start_sum;
   logic signed [WIDE_BITS-1:0] x_next_sum;
   logic signed [WIDE_BITS-1:0] y_next_sum;
   logic [SQ_BITS:0]            mag_sum;
   logic [SQ_BITS:0]            bound;
   logic                        escaped;
   logic                        xy_neg;
   logic [SQ_BITS:0]            xy_first;
   logic [SQ_BITS:0]            xy_term;
   logic [ITER_BITS-1:0]        count_next;
   logic                        load_out;
   logic                        limit_zero;

   // configuration registers
   jesc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // gray level divider
   jesc_gray_div u_gray_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared multiplier operand select
   always_comb begin
      mult_a = mx_ff;
      mult_b = mx_ff[HALF_BITS-1:0];
      case (state_ff)
         ST_START_X: begin
            mult_a = {{(Z_BITS-PITCH_BITS){1'b0}}, cfg.pixel_pitch};
            mult_b = {{(HALF_BITS-COORD_BITS){1'b0}}, col_ff};
         end
         ST_START_Y: begin
            mult_a = {{(Z_BITS-PITCH_BITS){1'b0}}, cfg.pixel_pitch};
            mult_b = {{(HALF_BITS-COORD_BITS){1'b0}}, row_ff};
         end
         ST_SQX_LO: begin
            mult_a = mx_ff;
            mult_b = mx_ff[HALF_BITS-1:0];
         end
         ST_SQX_HI: begin
            mult_a = mx_ff;
            mult_b = mx_ff[Z_BITS-1:HALF_BITS];
         end
         ST_SQY_LO: begin
            mult_a = my_ff;
            mult_b = my_ff[HALF_BITS-1:0];
         end
         ST_SQY_HI: begin
            mult_a = my_ff;
            mult_b = my_ff[Z_BITS-1:HALF_BITS];
         end
         ST_XY_LO: begin
            mult_a = mx_ff;
            mult_b = my_ff[HALF_BITS-1:0];
         end
         ST_XY_HI: begin
            mult_a = mx_ff;
            mult_b = my_ff[Z_BITS-1:HALF_BITS];
         end
         default: begin
            mult_a = mx_ff;
            mult_b = mx_ff[HALF_BITS-1:0];
         end
      endcase
   end

   // shared multiplier, registered product
   assign prod_in = {{HALF_BITS{1'b0}}, mult_a} * {{Z_BITS{1'b0}}, mult_b};

   // start point: origin plus index times pitch
   assign x_start_sum = {{(WIDE_BITS-COEF_BITS){cfg.x_origin[COEF_BITS-1]}}, cfg.x_origin}
                      + {{(WIDE_BITS-START_BITS){1'b0}}, prod_ff[START_BITS-1:0]};
   assign y_start_sum = {{(WIDE_BITS-COEF_BITS){cfg.y_origin[COEF_BITS-1]}}, cfg.y_origin}
                      + {{(WIDE_BITS-START_BITS){1'b0}}, prod_ff[START_BITS-1:0]};

   // escape test on the exact squared magnitude
   assign mag_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign bound   = {{(SQ_BITS+1-ESC_BITS-2*FRAC_BITS){1'b0}}, cfg.escape_sq,
                     {(2*FRAC_BITS){1'b0}}};
   assign escaped = (mag_sum > bound);

   // signed cross product, built from its magnitude
   assign xy_neg   = x_ff[Z_BITS-1] ^ y_ff[Z_BITS-1];
   assign xy_first = {{(SQ_BITS+1-PROD_BITS){1'b0}}, prod_ff};
   assign xy_term  = {1'b0, prod_ff, {HALF_BITS{1'b0}}};

   // next z: x*x - y*y + c_real and 2*x*y + c_imag, floored
   assign x_next_sum = {{(WIDE_BITS-XX_BITS){1'b0}}, sqx_ff[SQ_BITS-1:FRAC_BITS]}
                     - {{(WIDE_BITS-XX_BITS){1'b0}}, sqy_ff[SQ_BITS-1:FRAC_BITS]}
                     + {{(WIDE_BITS-COEF_BITS){cfg.c_real[COEF_BITS-1]}}, cfg.c_real};
   assign y_next_sum = {{(WIDE_BITS-XY_SH_BITS){xy_ff[SQ_BITS]}}, xy_ff[SQ_BITS:FRAC_BITS-1]}
                     + {{(WIDE_BITS-COEF_BITS){cfg.c_imag[COEF_BITS-1]}}, cfg.c_imag};

   assign count_next = count_ff + 1'b1;
   assign limit_zero = (cfg.iteration_limit == '0);

   // divider request: count * 255 over the limit
   assign div_req.start    = (state_ff == ST_DIV_GO);
   assign div_req.dividend = {count_ff, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, count_ff};
   assign div_req.divisor  = cfg.iteration_limit;

   assign load_out = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      xy_in    = xy_ff;
      count_in = count_ff;
      gray_in  = gray_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               col_in   = req_bus.col;
               row_in   = req_bus.row;
               state_in = ST_START_X;
            end
         end
         ST_START_X: state_in = ST_START_Y;
         ST_START_Y: begin
            x_in     = sat_z(x_start_sum);
            state_in = ST_LOAD_Y;
         end
         ST_LOAD_Y: begin
            y_in     = sat_z(y_start_sum);
            count_in = '0;
            state_in = limit_zero ? ST_DIV_GO : ST_MAG;
         end
         ST_MAG: begin
            mx_in    = mag_z(x_ff);
            my_in    = mag_z(y_ff);
            state_in = ST_SQX_LO;
         end
         ST_SQX_LO: state_in = ST_SQX_HI;
         ST_SQX_HI: begin
            sqx_in   = {{HALF_BITS{1'b0}}, prod_ff};
            state_in = ST_SQY_LO;
         end
         ST_SQY_LO: begin
            sqx_in   = sqx_ff + {prod_ff, {HALF_BITS{1'b0}}};
            state_in = ST_SQY_HI;
         end
         ST_SQY_HI: begin
            sqy_in   = {{HALF_BITS{1'b0}}, prod_ff};
            state_in = ST_XY_LO;
         end
         ST_XY_LO: begin
            sqy_in   = sqy_ff + {prod_ff, {HALF_BITS{1'b0}}};
            state_in = ST_XY_HI;
         end
         ST_XY_HI: begin
            xy_in    = xy_neg ? (SQ_BITS+1)'(-xy_first) : xy_first;
            state_in = escaped ? ST_DIV_GO : ST_XY_ACC;
         end
         ST_XY_ACC: begin
            xy_in    = xy_neg ? (xy_ff - xy_term) : (xy_ff + xy_term);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            x_in     = sat_z(x_next_sum);
            y_in     = sat_z(y_next_sum);
            count_in = count_next;
            state_in = (count_next == cfg.iteration_limit) ? ST_DIV_GO : ST_MAG;
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               gray_in  = limit_zero ? '0 : div_rsp.quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_count_in = out_count_ff;
      out_gray_in  = out_gray_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_count_in = count_ff;
         out_gray_in  = gray_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_count_ff <= out_count_in;
      out_gray_ff  <= out_gray_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      prod_ff      <= prod_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      xy_ff        <= xy_in;
      count_ff     <= count_in;
      gray_ff      <= gray_in;
   end

   // channel outputs
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.iter_count = out_count_ff;
   assign rsp_bus.gray       = out_gray_ff;

endmodule

`default_nettype wire

[test/julia_escape_time_pixel_unit_tb.sv]
// self-checking testbench of the julia escape-time pixel unit with a predicting scoreboard
`timescale 1ns / 1ps

module julia_escape_time_pixel_unit_tb;
   import jesc_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int      ITEM_GOAL      = 1700;
   localparam int      HOLD_CYCLES    = 400;
   localparam int      TAIL_CYCLES    = 300;
   localparam int      WATCHDOG_LIMIT = 50000;
   localparam longint  Z_TOP          = (64'sd1 <<< (Z_BITS - 1)) - 64'sd1;
   localparam longint  Z_BOTTOM       = -Z_TOP - 64'sd1;

   typedef struct packed {
      logic [ITER_BITS-1:0] iter_count;
      logic [GRAY_BITS-1:0] gray;
   } pixel_result_type;

   // shadow registers, escape-time predictor and queue of expected words
   class escape_scoreboard;
      jesc_cfg_type     regs;
      pixel_result_type expected_q[$];
      int unsigned      checked;
      int unsigned      mismatches;

      function new();
         regs.c_real          = C_REAL_RESET;
         regs.c_imag          = C_IMAG_RESET;
         regs.x_origin        = X_ORIGIN_RESET;
         regs.y_origin        = Y_ORIGIN_RESET;
         regs.pixel_pitch     = PITCH_RESET;
         regs.iteration_limit = LIMIT_RESET;
         regs.escape_sq       = ESCAPE_RESET;
         checked              = 0;
         mismatches           = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] sel, logic [CSR_DATA_BITS-1:0] word);
         case (sel)
            CSR_C_REAL:          regs.c_real          = word;
            CSR_C_IMAG:          regs.c_imag          = word;
            CSR_X_ORIGIN:        regs.x_origin        = word;
            CSR_Y_ORIGIN:        regs.y_origin        = word;
            CSR_PIXEL_PITCH:     regs.pixel_pitch     = word[PITCH_BITS-1:0];
            CSR_ITERATION_LIMIT: regs.iteration_limit = word[ITER_BITS-1:0];
            CSR_ESCAPE_SQ:       regs.escape_sq       = word[ESC_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_z(longint v);
         if (v > Z_TOP) return Z_TOP;
         if (v < Z_BOTTOM) return Z_BOTTOM;
         return v;
      endfunction

      // floor(a*b / 2^sh), capped at 2^62 in magnitude
      function longint fixed_mul(longint a, longint b, int sh);
         logic signed [127:0] wa, wb, prod, cap;
         wa   = a;
         wb   = b;
         cap  = 1;
         cap  = cap <<< 62;
         prod = (wa * wb) >>> sh;
         if (prod > cap) prod = cap;
         else if (prod < -cap) prod = -cap;
         return prod[63:0];
      endfunction

      function logic [127:0] square_mag(longint v);
         logic [127:0] m;
         m = (v < 0) ? -v : v;
         return m * m;
      endfunction

      function pixel_result_type escape_time(logic [COORD_BITS-1:0] col,
                                             logic [COORD_BITS-1:0] row);
         longint           col_l, row_l, pitch_l, x0, y0, cr, ci, zr, zi, sq_r, sq_i, prod_xy;
         logic [127:0]     bound;
         logic [31:0]      scaled;
         int unsigned      count;
         bit               escaped;
         pixel_result_type r;
         col_l   = col;
         row_l   = row;
         pitch_l = regs.pixel_pitch;
         x0      = $signed(regs.x_origin);
         y0      = $signed(regs.y_origin);
         cr      = $signed(regs.c_real);
         ci      = $signed(regs.c_imag);
         zr      = clamp_z(x0 + col_l * pitch_l);
         zi      = clamp_z(y0 + row_l * pitch_l);
         bound   = regs.escape_sq;
         bound   = bound << (2 * FRAC_BITS);
         count   = 0;
         escaped = 1'b0;
         // z = z*z + c until |z|^2 exceeds the bound or the limit is hit
         while (count < regs.iteration_limit && !escaped) begin
            if (square_mag(zr) + square_mag(zi) > bound) begin
               escaped = 1'b1;
            end else begin
               sq_r    = fixed_mul(zr, zr, FRAC_BITS);
               sq_i    = fixed_mul(zi, zi, FRAC_BITS);
               prod_xy = fixed_mul(zr, zi, FRAC_BITS - 1);
               zr      = clamp_z(sq_r - sq_i + cr);
               zi      = clamp_z(prod_xy + ci);
               count++;
            end
         end
         scaled       = (regs.iteration_limit == 0) ? 0 : (count * 255) / regs.iteration_limit;
         r.iter_count = count[ITER_BITS-1:0];
         r.gray       = scaled[GRAY_BITS-1:0];
         return r;
      endfunction

      function void note_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row);
         expected_q.push_back(escape_time(col, row));
      endfunction

      function void check_word(logic [ITER_BITS-1:0] iter_count, logic [GRAY_BITS-1:0] gray);
         pixel_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: iter_count %0d gray %0d", iter_count, gray);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.iter_count !== iter_count || want.gray !== gray) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result word %0d: expected iter_count %0d gray %0d, got %0d %0d",
                        checked, want.iter_count, want.gray, iter_count, gray);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   jesc_req_intf req_if();
   jesc_rsp_intf rsp_if();
   jesc_csr_intf csr_if();

   julia_escape_time_pixel_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   escape_scoreboard sb;
   bit               quiet_phase       = 1'b0;
   bit               long_hold_pending = 1'b0;
   int unsigned      pixels_sent       = 0;
   int unsigned      settings_applied  = 0;
   int unsigned      idle_cycles       = 0;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic int draw_gap();
      return quiet_phase ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [31:0] pick_coef();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
   endfunction

   // offer one pixel word, called at a falling edge
   task automatic put_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.col   <= col;
      req_if.row   <= row;
      do @(posedge clock); while (!req_if.ready);
      sb.note_pixel(col, row);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] sel,
                            input logic [CSR_DATA_BITS-1:0] word);
      csr_if.valid <= 1'b1;
      csr_if.index <= sel;
      csr_if.data  <= word;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(sel, word);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [31:0] c_re, input logic [31:0] c_im,
                               input logic [31:0] x0, input logic [31:0] y0,
                               input logic [31:0] pitch, input logic [31:0] limit,
                               input logic [31:0] esc);
      write_reg(CSR_C_REAL, c_re);
      write_reg(CSR_C_IMAG, c_im);
      write_reg(CSR_X_ORIGIN, x0);
      write_reg(CSR_Y_ORIGIN, y0);
      write_reg(CSR_PIXEL_PITCH, pitch);
      write_reg(CSR_ITERATION_LIMIT, limit);
      write_reg(CSR_ESCAPE_SQ, esc);
      csr_if.valid <= 1'b0;
      settings_applied++;
   endtask

   // drop valid and wait until every expected word is back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // result side with random back-pressure and one long hold-off
   initial begin : result_sink
      int gap;
      rsp_if.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            gap               = HOLD_CYCLES;
            long_hold_pending = 1'b0;
         end else begin
            gap = draw_gap();
         end
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         sb.check_word(rsp_if.iter_count, rsp_if.gray);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin : stimulus
      int          phase_no;
      int          burst;
      bit          big, pressure, messy;
      logic [31:0] limit, esc, pitch, x0, y0;
      sb = new();
      req_if.valid <= 1'b0;
      req_if.col   <= '0;
      req_if.row   <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data  <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: corners, center and an odd pixel
      put_pixel(0, 0);
      put_pixel(1023, 1023);
      put_pixel(0, 1023);
      put_pixel(1023, 0);
      put_pixel(250, 250);
      put_pixel(683, 341);
      drain();

      // zero limit runs no iteration
      program_regs(C_REAL_RESET, C_IMAG_RESET, X_ORIGIN_RESET, Y_ORIGIN_RESET,
                   32'(PITCH_RESET), 0, 32'(ESCAPE_RESET));
      put_pixel(0, 0);
      put_pixel(1023, 1023);
      put_pixel(512, 512);
      drain();

      // zero escape bound: only z = 0 iterates
      program_regs(0, 0, 0, 0, 1, 5, 0);
      put_pixel(0, 0);
      put_pixel(1, 0);
      put_pixel(0, 1);
      drain();

      // far start points saturate, maximum pitch and coefficients
      program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 1023, 255);
      put_pixel(1023, 1023);
      put_pixel(0, 0);
      put_pixel(1023, 0);
      put_pixel(0, 1023);
      drain();

      // most negative coefficients with zero pitch
      program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1023, 255);
      put_pixel(0, 0);
      put_pixel(1023, 1023);
      drain();

      // interior points that run to the full limit, plus a write to the spare index
      write_reg(CSR_UNUSED_INDEX, $urandom);
      program_regs(0, 0, 32'hF800_0000, 32'hF800_0000, 32'h0002_0000, 1023, 4);
      put_pixel(0, 0);
      put_pixel(1023, 1023);
      drain();

      // random settings, mostly small limits, a few long ones
      phase_no = 0;
      while (pixels_sent < ITEM_GOAL) begin
         big      = ($urandom_range(0, 7) == 0);
         pressure = (phase_no == 2);
         messy    = $urandom_range(0, 1);
         limit    = big ? $urandom_range(41, 1023) : $urandom_range(0, 40);
         if (pressure) limit = $urandom_range(1, 12);
         esc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(4, 16);
         pitch = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1 << 16, 1 << 20);
         x0 = ($urandom_range(0, 7) == 0) ? $urandom : 32'd0 - $urandom_range(1 << 28, 1 << 29);
         y0 = ($urandom_range(0, 7) == 0) ? $urandom : 32'd0 - $urandom_range(1 << 28, 1 << 29);
         if (messy) begin
            limit = limit | ($urandom & ~32'h3FF);
            esc   = esc | ($urandom & ~32'hFF);
         end
         program_regs(pick_coef(), pick_coef(), x0, y0, pitch, limit, esc);
         quiet_phase       = pressure || ($urandom_range(0, 3) == 0);
         long_hold_pending = pressure;
         burst             = big ? 8 : 100;
         repeat (burst) put_pixel(COORD_BITS'($urandom_range(0, 1023)),
                                  COORD_BITS'($urandom_range(0, 1023)));
         drain();
         quiet_phase = 1'b0;
         phase_no++;
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("sent %0d pixels under %0d register settings, checked %0d result words",
               pixels_sent, settings_applied, sb.checked);
      $display("covered zero limit, zero escape bound, saturated starts, full-limit pixels,");
      $display("random back-pressure and a long receiver hold-off; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[julia_escape_time_pixel_unit.f]
hw/rtl/jesc_pkg.sv
hw/rtl/jesc_intf.sv
hw/rtl/jesc_csr.sv
hw/rtl/jesc_gray_div.sv
hw/rtl/julia_escape_time_pixel_unit.sv
test/julia_escape_time_pixel_unit_tb.sv
